/* sv/wavpd_pkg.sv */
package wavpd_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [32:0] MIN_LEN  = 33'd44;
    localparam logic [31:0] FMT_MIN  = 32'd16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RIFF    = 3'd1;
    localparam logic [2:0] ST_PCM     = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_BITS    = 3'd4;
    localparam logic [2:0] ST_ZERO    = 3'd5;
    localparam logic [2:0] ST_MONO    = 3'd6;
    localparam logic [2:0] ST_LAYOUT  = 3'd7;

    localparam logic CFG_LENGTH = 1'b0;
    localparam logic CFG_MONO   = 1'b1;

    localparam int QW = 41;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HEAD,
        PH_BODY,
        PH_PAD,
        PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DIV,
        SQ_SAMPLE,
        SQ_STATUS
    } seq_t;

    typedef struct packed {
        logic start;
        logic neg;
        logic [QW-1:0] num;
        logic [16:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [QW-1:0] quot;
    } div_rsp_t;

endpackage

/* sv/wav_pcm16_parse_downmix_unit.sv */
// Byte-serial RIFF/WAVE 16-bit PCM parser with channel-mean downmix. One byte is
// taken per request; after a byte that causes no result the block is ready again
// on the next cycle, as it is once any result has been taken. A byte that
// completes a data frame starts a restoring divider that produces one quotient
// bit per cycle, and no further byte is taken until the sample of that frame has
// been taken, and the final status too when that byte is also the last
// one of the buffer. Writing buffer_length clears all parse state; writes are taken
// only while the block is idle. Sample results arrive before the final status,
// so discard them when the status is nonzero.
module wav_pcm16_parse_downmix_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         wav_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic signed [23:0] sample,
    output logic [2:0]         status,
    output logic [31:0]        fmt_rate,
    output logic [15:0]        channel_count,
    output logic [30:0]        frame_count,
    output logic               last
);

    wavpd_pkg::seq_t seq_reg, seq_next;
    wavpd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] len_reg, len_next;
    logic mono_reg, mono_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] clen_reg, clen_next;
    logic [31:0] off_reg, off_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [3:0] flags_reg, flags_next;
    logic [2:0] err_reg, err_next;
    logic [7:0] low_reg, low_next;
    logic [15:0] cidx_reg, cidx_next;
    logic [31:0] sum_reg, sum_next;
    logic [30:0] frames_reg, frames_next;
    logic pend_reg, pend_next;
    logic neg_reg, neg_next;
    logic [23:0] smp_reg, smp_next;

    wavpd_pkg::div_req_t dreq;
    wavpd_pkg::div_rsp_t drsp;

    wavpd_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    logic [2:0] fstat;
    logic usable;
    logic [31:0] new_tag, new_len, new_sum, mag;
    logic [15:0] cidx_inc;
    logic [31:0] off_inc;
    logic [40:0] qneg;
    logic [32:0] p33;

    always_comb
    begin
        fstat = wavpd_pkg::ST_OK;
        if (err_reg != wavpd_pkg::ST_OK)
            fstat = err_reg;
        else if (!flags_reg[0] || !flags_reg[1])
            fstat = wavpd_pkg::ST_MISSING;
        else if (bits_reg != 16'd16)
            fstat = wavpd_pkg::ST_BITS;
        else if (ch_reg == 16'd0)
            fstat = wavpd_pkg::ST_ZERO;
        else if (mono_reg && ch_reg != 16'd1)
            fstat = wavpd_pkg::ST_MONO;
    end

    always_comb
    begin
        seq_next = seq_reg;
        phase_next = phase_reg;
        len_next = len_reg;
        mono_next = mono_reg;
        pos_next = pos_reg;
        tag_next = tag_reg;
        clen_next = clen_reg;
        off_next = off_reg;
        fmt_next = fmt_reg;
        ch_next = ch_reg;
        rate_next = rate_reg;
        bits_next = bits_reg;
        flags_next = flags_reg;
        err_next = err_reg;
        low_next = low_reg;
        cidx_next = cidx_reg;
        sum_next = sum_reg;
        frames_next = frames_reg;
        pend_next = pend_reg;
        neg_next = neg_reg;
        smp_next = smp_reg;
        dreq = '0;
        usable = (bits_reg == 16'd16) && (ch_reg != 16'd0) && !(mono_reg && ch_reg != 16'd1);
        new_tag = {wav_byte, tag_reg[31:8]};
        new_len = {wav_byte, clen_reg[31:8]};
        new_sum = sum_reg + 32'(signed'({wav_byte, low_reg}));
        mag = new_sum[31] ? (32'd0 - new_sum) : new_sum;
        cidx_inc = cidx_reg + 16'd1;
        off_inc = off_reg + 32'd1;
        qneg = 41'd0 - drsp.quot;
        p33 = {1'b0, pos_reg};
        cfg_ready = (seq_reg == wavpd_pkg::SQ_IDLE);
        in_ready = (seq_reg == wavpd_pkg::SQ_IDLE) && !cfg_valid;
        out_valid = (seq_reg == wavpd_pkg::SQ_SAMPLE) || (seq_reg == wavpd_pkg::SQ_STATUS);
        kind = (seq_reg == wavpd_pkg::SQ_STATUS);
        last = kind;
        sample = kind ? 24'sd0 : smp_reg;
        status = kind ? fstat : wavpd_pkg::ST_OK;
        fmt_rate = (kind && fstat == wavpd_pkg::ST_OK) ? rate_reg : 32'd0;
        channel_count = (kind && fstat == wavpd_pkg::ST_OK) ? ch_reg : 16'd0;
        frame_count = (kind && fstat == wavpd_pkg::ST_OK) ? frames_reg : 31'd0;

        case (seq_reg)
            wavpd_pkg::SQ_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == wavpd_pkg::CFG_LENGTH)
                    begin
                        len_next = cfg_data;
                        pos_next = '0;
                        phase_next = wavpd_pkg::PH_RIFF;
                        tag_next = '0;
                        clen_next = '0;
                        off_next = '0;
                        fmt_next = '0;
                        ch_next = '0;
                        rate_next = '0;
                        bits_next = '0;
                        flags_next = '0;
                        err_next = '0;
                        low_next = '0;
                        cidx_next = '0;
                        sum_next = '0;
                        frames_next = '0;
                    end
                    else
                    begin
                        mono_next = cfg_data[0];
                    end
                end
                else if (in_valid && pos_reg < len_reg)
                begin
                    pend_next = (pos_reg + 32'd1 == len_reg);
                    pos_next = pos_reg + 32'd1;
                    if (pend_next)
                        seq_next = wavpd_pkg::SQ_STATUS;
                    if (err_reg == wavpd_pkg::ST_OK)
                    begin
                        case (phase_reg)
                            wavpd_pkg::PH_RIFF:
                            begin
                                if (pos_reg == 32'd0 && {1'b0, len_reg} < wavpd_pkg::MIN_LEN)
                                    err_next = wavpd_pkg::ST_RIFF;
                                else
                                begin
                                    tag_next = new_tag;
                                    if ((pos_reg == 32'd3 && new_tag != wavpd_pkg::TAG_RIFF)
                                        || (pos_reg == 32'd11 && new_tag != wavpd_pkg::TAG_WAVE))
                                        err_next = wavpd_pkg::ST_RIFF;
                                    else if (pos_reg == 32'd11)
                                    begin
                                        phase_next = wavpd_pkg::PH_HEAD;
                                        off_next = '0;
                                    end
                                end
                            end
                            wavpd_pkg::PH_HEAD:
                            begin
                                if (off_reg == 32'd0 && p33 + 33'd8 > {1'b0, len_reg})
                                    phase_next = wavpd_pkg::PH_STOP;
                                else
                                begin
                                    if (off_reg < 32'd4)
                                        tag_next = new_tag;
                                    else
                                        clen_next = new_len;
                                    off_next = off_inc;
                                    if (off_inc == 32'd8)
                                    begin
                                        off_next = '0;
                                        if (p33 + 33'd1 + {1'b0, new_len} > {1'b0, len_reg})
                                            phase_next = wavpd_pkg::PH_STOP;
                                        else
                                        begin
                                            flags_next[3:2] = 2'b00;
                                            phase_next = (new_len == 32'd0) ?
                                                wavpd_pkg::PH_HEAD : wavpd_pkg::PH_BODY;
                                            if (tag_reg == wavpd_pkg::TAG_DATA)
                                            begin
                                                if (!flags_reg[0] || flags_reg[1])
                                                begin
                                                    err_next = wavpd_pkg::ST_LAYOUT;
                                                    phase_next = phase_reg;
                                                    off_next = off_inc;
                                                end
                                                else
                                                begin
                                                    flags_next[1] = 1'b1;
                                                    flags_next[3] = 1'b1;
                                                    sum_next = '0;
                                                    cidx_next = '0;
                                                end
                                            end
                                            else if (tag_reg == wavpd_pkg::TAG_FMT
                                                     && new_len >= wavpd_pkg::FMT_MIN)
                                            begin
                                                if (flags_reg[1])
                                                begin
                                                    err_next = wavpd_pkg::ST_LAYOUT;
                                                    phase_next = phase_reg;
                                                    off_next = off_inc;
                                                end
                                                else
                                                    flags_next[2] = 1'b1;
                                            end
                                        end
                                    end
                                end
                            end
                            wavpd_pkg::PH_BODY:
                            begin
                                off_next = off_inc;
                                if (off_inc == clen_reg)
                                begin
                                    flags_next[3:2] = 2'b00;
                                    off_next = '0;
                                    phase_next = clen_reg[0] ?
                                        wavpd_pkg::PH_PAD : wavpd_pkg::PH_HEAD;
                                end
                                if (flags_reg[2])
                                begin
                                    case (off_reg)
                                        32'd0: fmt_next = {8'd0, wav_byte};
                                        32'd1: fmt_next = {wav_byte, fmt_reg[7:0]};
                                        32'd2: ch_next = {8'd0, wav_byte};
                                        32'd3: ch_next = {wav_byte, ch_reg[7:0]};
                                        32'd4: rate_next = {24'd0, wav_byte};
                                        32'd5: rate_next[15:8] = wav_byte;
                                        32'd6: rate_next[23:16] = wav_byte;
                                        32'd7: rate_next[31:24] = wav_byte;
                                        32'd14: bits_next = {8'd0, wav_byte};
                                        32'd15:
                                        begin
                                            bits_next = {wav_byte, bits_reg[7:0]};
                                            if (fmt_reg != 16'd1)
                                            begin
                                                err_next = wavpd_pkg::ST_PCM;
                                                off_next = off_reg;
                                                flags_next = flags_reg;
                                                phase_next = phase_reg;
                                            end
                                            else
                                                flags_next[0] = 1'b1;
                                        end
                                        default: ;
                                    endcase
                                end
                                else if (flags_reg[3] && usable)
                                begin
                                    if (!off_reg[0])
                                        low_next = wav_byte;
                                    else
                                    begin
                                        sum_next = new_sum;
                                        cidx_next = cidx_inc;
                                        if (cidx_inc >= ch_reg)
                                        begin
                                            sum_next = '0;
                                            cidx_next = '0;
                                            frames_next = frames_reg + 31'd1;
                                            neg_next = new_sum[31];
                                            dreq.start = 1'b1;
                                            dreq.num = {mag, 9'd0} + {25'd0, ch_reg};
                                            dreq.den = {ch_reg, 1'b0};
                                            seq_next = wavpd_pkg::SQ_DIV;
                                        end
                                    end
                                end
                            end
                            wavpd_pkg::PH_PAD:
                            begin
                                phase_next = wavpd_pkg::PH_HEAD;
                                off_next = '0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            wavpd_pkg::SQ_DIV:
            begin
                if (drsp.done)
                begin
                    smp_next = neg_reg ? qneg[23:0] : drsp.quot[23:0];
                    seq_next = wavpd_pkg::SQ_SAMPLE;
                end
            end
            wavpd_pkg::SQ_SAMPLE:
            begin
                if (out_ready)
                    seq_next = pend_reg ? wavpd_pkg::SQ_STATUS : wavpd_pkg::SQ_IDLE;
            end
            wavpd_pkg::SQ_STATUS:
            begin
                if (out_ready)
                    seq_next = wavpd_pkg::SQ_IDLE;
            end
            default: seq_next = wavpd_pkg::SQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= wavpd_pkg::SQ_IDLE;
            phase_reg <= wavpd_pkg::PH_RIFF;
            len_reg <= '0;
            mono_reg <= 1'b0;
            pos_reg <= '0;
            tag_reg <= '0;
            clen_reg <= '0;
            off_reg <= '0;
            fmt_reg <= '0;
            ch_reg <= '0;
            rate_reg <= '0;
            bits_reg <= '0;
            flags_reg <= '0;
            err_reg <= '0;
            low_reg <= '0;
            cidx_reg <= '0;
            sum_reg <= '0;
            frames_reg <= '0;
            pend_reg <= 1'b0;
            neg_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            phase_reg <= phase_next;
            len_reg <= len_next;
            mono_reg <= mono_next;
            pos_reg <= pos_next;
            tag_reg <= tag_next;
            clen_reg <= clen_next;
            off_reg <= off_next;
            fmt_reg <= fmt_next;
            ch_reg <= ch_next;
            rate_reg <= rate_next;
            bits_reg <= bits_next;
            flags_reg <= flags_next;
            err_reg <= err_next;
            low_reg <= low_next;
            cidx_reg <= cidx_next;
            sum_reg <= sum_next;
            frames_reg <= frames_next;
            pend_reg <= pend_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

endmodule

/* sv/wavpd_divider.sv */
module wavpd_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  wavpd_pkg::div_req_t req,
    output wavpd_pkg::div_rsp_t rsp
);

    logic [wavpd_pkg::QW-1:0] quot_reg, quot_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [17:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (req.start)
        begin
            quot_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = 6'(wavpd_pkg::QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[16:0], quot_reg[wavpd_pkg::QW-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quot_next = {quot_reg[wavpd_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quot_next = {quot_reg[wavpd_pkg::QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* sim/tb_wav_pcm16_parse_downmix_unit.sv */
`timescale 1ns / 100ps

module tb_wav_pcm16_parse_downmix_unit;

    typedef struct {
        logic               kind;
        logic signed [23:0] sample;
        logic [2:0]         status;
        logic [31:0]        fmt_rate;
        logic [15:0]        channel_count;
        logic [30:0]        frame_count;
        logic               last;
    } wav_result_t;

    class wav_scoreboard;
        bit [31:0]          buf_len;
        bit                 mono_only;
        bit [31:0]          pos;
        wavpd_pkg::phase_t  phase;
        bit [31:0]          tag;
        bit [31:0]          clen;
        bit [31:0]          off;
        bit [15:0]          fmt_code;
        bit [15:0]          chans;
        bit [31:0]          rate;
        bit [15:0]          bits;
        bit                 fmt_seen, data_seen, in_fmt, in_data;
        bit [2:0]           err;
        bit [7:0]           low;
        bit [15:0]          chan_idx;
        int                 frame_sum;
        bit [30:0]          frames;
        wav_result_t        expected_q[$];
        int                 mismatches;
        int                 samples_seen;
        int                 status_seen[8];

        function void clear_parse();
            pos = 0; phase = wavpd_pkg::PH_RIFF; tag = 0; clen = 0; off = 0;
            fmt_code = 0; chans = 0; rate = 0; bits = 0;
            fmt_seen = 0; data_seen = 0; in_fmt = 0; in_data = 0;
            err = wavpd_pkg::ST_OK; low = 0; chan_idx = 0; frame_sum = 0; frames = 0;
        endfunction

        function void write_reg(logic idx, bit [31:0] v);
            if (idx == wavpd_pkg::CFG_LENGTH)
            begin
                buf_len = v;
                clear_parse();
            end
            else
                mono_only = v[0];
        endfunction

        function void push(logic k, logic signed [23:0] s, logic [2:0] st,
                           logic [31:0] r, logic [15:0] c, logic [30:0] f);
            wav_result_t e;
            e.kind = k; e.sample = s; e.status = st; e.fmt_rate = r;
            e.channel_count = c; e.frame_count = f; e.last = k;
            expected_q.insert(expected_q.size(), e);
        endfunction

        function logic signed [23:0] mean_of(int sum, bit [15:0] ch);
            bit          neg;
            longint      mag;
            longint      q;
            neg = sum < 0;
            mag = neg ? -longint'(sum) : longint'(sum);
            q = (mag * 512 + ch) / (2 * longint'(ch));
            if (neg)
                q = -q;
            return q[23:0];
        endfunction

        function void data_byte(bit [7:0] b);
            logic signed [15:0] v;
            if (bits != 16 || chans == 0 || (mono_only && chans != 1))
                return;
            if (!off[0])
            begin
                low = b;
                return;
            end
            v = {b, low};
            frame_sum += v;
            chan_idx++;
            if (chan_idx < chans)
                return;
            push(1'b0, mean_of(frame_sum, chans), wavpd_pkg::ST_OK, 0, 0, 0);
            frames++;
            frame_sum = 0;
            chan_idx = 0;
        endfunction

        function void start_chunk();
            in_fmt = 0; in_data = 0;
            if (tag == wavpd_pkg::TAG_DATA)
            begin
                if (!fmt_seen || data_seen)
                begin
                    err = wavpd_pkg::ST_LAYOUT;
                    return;
                end
                data_seen = 1; in_data = 1; frame_sum = 0; chan_idx = 0;
            end
            else if (tag == wavpd_pkg::TAG_FMT && clen >= wavpd_pkg::FMT_MIN)
            begin
                if (data_seen)
                begin
                    err = wavpd_pkg::ST_LAYOUT;
                    return;
                end
                in_fmt = 1;
            end
            off = 0;
            phase = (clen == 0) ? wavpd_pkg::PH_HEAD : wavpd_pkg::PH_BODY;
        endfunction

        function void fmt_byte(bit [7:0] b);
            case (off)
                0: fmt_code[7:0] = b;
                1: fmt_code[15:8] = b;
                2: chans[7:0] = b;
                3: chans[15:8] = b;
                4: rate = {24'd0, b};
                5: rate[15:8] = b;
                6: rate[23:16] = b;
                7: rate[31:24] = b;
                14: bits = {8'd0, b};
                15:
                begin
                    bits[15:8] = b;
                    if (fmt_code != 1)
                        err = wavpd_pkg::ST_PCM;
                    else
                        fmt_seen = 1;
                end
                default: ;
            endcase
        endfunction

        function void walk(bit [7:0] b);
            longint unsigned len;
            longint unsigned p;
            len = buf_len;
            p = pos;
            case (phase)
                wavpd_pkg::PH_RIFF:
                begin
                    if (p == 0 && len < wavpd_pkg::MIN_LEN)
                    begin
                        err = wavpd_pkg::ST_RIFF;
                        return;
                    end
                    tag = {b, tag[31:8]};
                    if ((p == 3 && tag != wavpd_pkg::TAG_RIFF)
                        || (p == 11 && tag != wavpd_pkg::TAG_WAVE))
                    begin
                        err = wavpd_pkg::ST_RIFF;
                        return;
                    end
                    if (p == 11)
                    begin
                        phase = wavpd_pkg::PH_HEAD;
                        off = 0;
                    end
                end
                wavpd_pkg::PH_HEAD:
                begin
                    if (off == 0 && p + 8 > len)
                    begin
                        phase = wavpd_pkg::PH_STOP;
                        return;
                    end
                    if (off < 4)
                        tag = {b, tag[31:8]};
                    else
                        clen = {b, clen[31:8]};
                    off++;
                    if (off == 8)
                    begin
                        off = 0;
                        if (p + 1 + longint'(clen) > len)
                            phase = wavpd_pkg::PH_STOP;
                        else
                            start_chunk();
                    end
                end
                wavpd_pkg::PH_BODY:
                begin
                    if (in_fmt)
                    begin
                        fmt_byte(b);
                        if (err != wavpd_pkg::ST_OK)
                            return;
                    end
                    else if (in_data)
                        data_byte(b);
                    off++;
                    if (off == clen)
                    begin
                        in_fmt = 0; in_data = 0; off = 0;
                        phase = clen[0] ? wavpd_pkg::PH_PAD : wavpd_pkg::PH_HEAD;
                    end
                end
                wavpd_pkg::PH_PAD:
                begin
                    phase = wavpd_pkg::PH_HEAD;
                    off = 0;
                end
                default: ;
            endcase
        endfunction

        function void note_byte(bit [7:0] b);
            logic [2:0] st;
            if (longint'(pos) >= longint'(buf_len))
                return;
            if (err == wavpd_pkg::ST_OK)
                walk(b);
            if (longint'(pos) + 1 == longint'(buf_len))
            begin
                if (err != wavpd_pkg::ST_OK)
                    st = err;
                else if (!fmt_seen || !data_seen)
                    st = wavpd_pkg::ST_MISSING;
                else if (bits != 16)
                    st = wavpd_pkg::ST_BITS;
                else if (chans == 0)
                    st = wavpd_pkg::ST_ZERO;
                else if (mono_only && chans != 1)
                    st = wavpd_pkg::ST_MONO;
                else
                    st = wavpd_pkg::ST_OK;
                if (st == wavpd_pkg::ST_OK)
                    push(1'b1, 0, wavpd_pkg::ST_OK, rate, chans, frames);
                else
                    push(1'b1, 0, st, 0, 0, 0);
            end
            pos++;
        endfunction

        function void check_result(wav_result_t got);
            wav_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d sample %0d status %0d",
                             got.kind, got.sample, got.status);
                return;
            end
            e = expected_q.pop_front();
            if (got.kind)
                status_seen[got.status]++;
            else
                samples_seen++;
            if (got.kind !== e.kind || got.sample !== e.sample ||
                got.status !== e.status || got.fmt_rate !== e.fmt_rate ||
                got.channel_count !== e.channel_count ||
                got.frame_count !== e.frame_count || got.last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected k%0d s%0d st%0d r%0d c%0d f%0d l%0d,",
                              " got k%0d s%0d st%0d r%0d c%0d f%0d l%0d"},
                             e.kind, e.sample, e.status, e.fmt_rate,
                             e.channel_count, e.frame_count, e.last,
                             got.kind, got.sample, got.status, got.fmt_rate,
                             got.channel_count, got.frame_count, got.last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [0:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         wav_byte;
    logic               out_valid;
    logic               out_ready;
    logic               kind;
    logic signed [23:0] sample;
    logic [2:0]         status;
    logic [31:0]        fmt_rate;
    logic [15:0]        channel_count;
    logic [30:0]        frame_count;
    logic               last;

    wav_scoreboard sb;
    bit [7:0]      wave_q[$];
    int            bytes_sent;
    int            buffers_sent;
    int            results_taken;
    bit            held_off;

    wav_pcm16_parse_downmix_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .wav_byte(wav_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .sample(sample),
        .status(status),
        .fmt_rate(fmt_rate),
        .channel_count(channel_count),
        .frame_count(frame_count),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        wav_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind = kind; got.sample = sample; got.status = status;
            got.fmt_rate = fmt_rate; got.channel_count = channel_count;
            got.frame_count = frame_count; got.last = last;
            sb.check_result(got);
            results_taken++;
        end
    end

    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = $urandom_range(0, 13);
            if (!held_off && results_taken >= 2)
            begin
                held_off = 1;
                n = 400;
            end
            if (n != 0)
            begin
                out_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic send_byte(bit [7:0] b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        wav_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic write_reg(logic idx, bit [31:0] v);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic put32(bit [31:0] v);
        for (int i = 0; i < 4; i++)
            wave_q.insert(wave_q.size(), v[8*i +: 8]);
    endtask

    task automatic put_fmt(bit [15:0] code, bit [15:0] ch, bit [31:0] rate, bit [15:0] bits);
        put32(wavpd_pkg::TAG_FMT);
        put32(16);
        put32({ch, code});
        put32(rate);
        put32($urandom);
        put32({bits, 16'($urandom)});
    endtask

    task automatic put_data(int dsz, bit extremes);
        bit [7:0] pat[4] = '{8'h00, 8'h80, 8'hFF, 8'h7F};
        put32(wavpd_pkg::TAG_DATA);
        put32(dsz);
        for (int i = 0; i < dsz; i++)
            wave_q.insert(wave_q.size(), extremes ? pat[i % 4] : 8'($urandom));
    endtask

    // order: 0 normal, 1 data before fmt, 2 two data chunks, 3 fmt after data
    task automatic build_wave(bit [15:0] code, bit [15:0] ch, bit [15:0] bits, int dsz,
                              bit junk, int order, bit extremes);
        wave_q.delete();
        put32(wavpd_pkg::TAG_RIFF);
        put32($urandom);
        put32(wavpd_pkg::TAG_WAVE);
        if (junk)
        begin
            put32(32'h5453_494C);
            put32(3);
            repeat (4) wave_q.insert(wave_q.size(), 8'($urandom));
        end
        if (order == 1)
            put_data(dsz, extremes);
        put_fmt(code, ch, $urandom, bits);
        put_data(dsz, extremes);
        if (order == 2)
            put_data(4, 0);
        if (order == 3)
            put_fmt(code, ch, $urandom, bits);
    endtask

    task automatic run_buffer(bit [31:0] len, bit mono, int extra);
        write_reg(wavpd_pkg::CFG_LENGTH, len);
        write_reg(wavpd_pkg::CFG_MONO, mono);
        foreach (wave_q[i])
            send_byte(wave_q[i]);
        repeat (extra) send_byte(8'($urandom));
        buffers_sent++;
    endtask

    initial
    begin
        int ch;
        int dsz;
        int sel;
        int len;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = wavpd_pkg::CFG_LENGTH;
        cfg_data = 0;
        in_valid = 1'b0;
        wav_byte = 0;
        sb = new();
        sb.mono_only = 0;
        sb.buf_len = 0;
        sb.clear_parse();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        build_wave(1, 1, 16, 8, 0, 0, 1);
        run_buffer(wave_q.size(), 1, 0);
        build_wave(1, 2, 16, 9, 1, 0, 1);
        run_buffer(wave_q.size(), 0, 2);
        wave_q = '{8'h52, 8'h49, 8'h46, 8'h46};
        run_buffer(43, 0, 0);
        run_buffer(0, 0, 0);
        build_wave(3, 1, 16, 2, 0, 0, 0);
        run_buffer(wave_q.size(), 0, 0);
        build_wave(1, 0, 16, 4, 0, 0, 0);
        run_buffer(wave_q.size(), 0, 0);
        build_wave(1, 2, 8, 4, 0, 0, 0);
        run_buffer(wave_q.size(), 1, 0);
        build_wave(1, 2, 16, 4, 0, 1, 0);
        run_buffer(wave_q.size(), 0, 0);
        build_wave(1, 1, 16, 3, 0, 2, 0);
        run_buffer(wave_q.size(), 0, 0);
        build_wave(1, 1, 16, 4, 0, 3, 0);
        run_buffer(wave_q.size(), 0, 0);
        build_wave(1, 3, 16, 6, 0, 0, 0);
        run_buffer(32'hFFFF_FFFF, 0, 0);

        while (bytes_sent < 650)
        begin
            ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4);
            dsz = (ch <= 4) ? ch * 2 * $urandom_range(1, 8) + $urandom_range(0, 3)
                            : $urandom_range(0, 6);
            sel = $urandom_range(0, 19);
            build_wave((sel == 0) ? 16'($urandom) : 16'd1, 16'(ch),
                       (sel == 1) ? 16'($urandom) : 16'd16, dsz,
                       $urandom_range(0, 1), (sel == 2) ? $urandom_range(1, 3) : 0, 0);
            len = wave_q.size();
            if (sel == 3)
                len = len - $urandom_range(1, 10);
            if (sel == 4)
                wave_q[$urandom_range(0, wave_q.size() - 1)] = 8'($urandom);
            run_buffer(len, $urandom_range(0, 3) == 0, (sel == 5) ? 3 : 0);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d buffers, %0d bytes, %0d frame means checked", buffers_sent,
                 bytes_sent, sb.samples_seen);
        $display("status counts ok..layout: %0d %0d %0d %0d %0d %0d %0d %0d; mismatches %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4], sb.status_seen[5],
                 sb.status_seen[6], sb.status_seen[7], sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
